/* hdl/clamp_median_weighted_mean_core_assert.svh */
// Assertion macros shared by the clamp/median/weighted-mean core.
`ifndef CLAMP_MEDIAN_WEIGHTED_MEAN_CORE_ASSERT_SVH
`define CLAMP_MEDIAN_WEIGHTED_MEAN_CORE_ASSERT_SVH

// Same-cycle implication: when cond holds, expr must hold on that edge.
`define CMWM_ASSERT_SAME(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

// Next-cycle implication: when cond holds, expr must hold on the next edge.
`define CMWM_ASSERT_NEXT(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`endif

/* hdl/cmwm_pkg.sv */
// Shared constants, weight tables and control structs of the clamp/median/mean core.
package cmwm_pkg;

    localparam int WINDOW_LEN      = 5;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CNT_W           = 3;
    localparam int WEIGHT_W        = 7;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH = 1'b1;

    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] count;
    } scan_ctl_t;

    typedef struct packed {
        logic mac_done;
        logic rank_done;
    } scan_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Weight of the sample at a given age, newest first.
    function automatic logic [WEIGHT_W-1:0] weight_of(input logic [CNT_W-1:0] pos);
        logic [WEIGHT_W-1:0] w;
        case (pos)
            3'd0:    w = 7'd40;
            3'd1:    w = 7'd30;
            3'd2:    w = 7'd15;
            3'd3:    w = 7'd10;
            3'd4:    w = 7'd5;
            default: w = 7'd0;
        endcase
        return w;
    endfunction

    // Sum of the weights of the newest n samples.
    function automatic logic [WEIGHT_W-1:0] total_weight(input logic [CNT_W-1:0] n);
        logic [WEIGHT_W-1:0] t;
        case (n)
            3'd1:    t = 7'd40;
            3'd2:    t = 7'd70;
            3'd3:    t = 7'd85;
            3'd4:    t = 7'd95;
            default: t = 7'd100;
        endcase
        return t;
    endfunction

endpackage

/* hdl/clamp_median_weighted_mean_core.sv */
// Top level of the clamp, running median and weighted moving average core.
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid / s_tready  s_tdata: raw_sample
//  m_*       out        m_tvalid / m_tready  m_tdata: clamped, median, mean_q8, fill
//  cfg_*     in         cfg_wr_en only       cfg_index, cfg_wr_data
//
//  m_tvalid rises once the rank scan and the bit-serial divider have both finished; the
//  divider runs one quotient bit a cycle over SAMPLE_BITS + 14 bits, and the rank scan
//  for the median overlaps the divide. A new request is taken only after the last
//  result has moved to the output register.
//  aresetn is synchronous, active low; it clears the window and fill count and resets the limits.
//  s_tready is high only while idle; a stalled m_tready holds the result register,
//  and the next request is still taken while a result waits.
`include "clamp_median_weighted_mean_core_assert.svh"

module clamp_median_weighted_mean_core
    import cmwm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_FIELDS_W = 3 * SAMPLE_BITS + 8 + CNT_W,
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8,
    localparam int ACC_W      = SAMPLE_BITS + 7,
    localparam int MEAN_W     = SAMPLE_BITS + 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SAMPLE_BITS-1:0] cfg_wr_data,
    // sample requests
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // raw_sample
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // clamped_sample, median_value,
                                              // weighted_mean_q8, fill_count
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0]          clamp_low_reg, clamp_high_reg;
    logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] ring_reg, ring_next;
    logic [CNT_W-1:0]                       fill_reg, fill_next;
    logic signed [SAMPLE_BITS-1:0]          clamped_reg;

    logic                                   m_tvalid_reg;
    logic signed [SAMPLE_BITS-1:0]          m_clamped_reg, m_median_reg;
    logic signed [MEAN_W-1:0]               m_mean_reg;
    logic [CNT_W-1:0]                       m_fill_reg;

    logic signed [SAMPLE_BITS-1:0]          raw, clamp_val;
    logic                                   accept, out_free;

    scan_ctl_t                              scan_ctl;
    scan_stat_t                             scan_stat;
    div_stat_t                              div_stat;
    logic signed [ACC_W-1:0]                acc;
    logic signed [SAMPLE_BITS-1:0]          median;
    logic signed [MEAN_W-1:0]               quotient;

    // Clamp: test the low limit first, then the high limit.
    always_comb begin
        raw = $signed(s_tdata[SAMPLE_BITS-1:0]);
        if (raw < clamp_low_reg) begin
            clamp_val = clamp_low_reg;
        end else if (raw > clamp_high_reg) begin
            clamp_val = clamp_high_reg;
        end else begin
            clamp_val = raw;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Window as a shift line, newest sample in place zero.
    always_comb begin
        ring_next[0] = clamp_val;
        for (int k = 1; k < WINDOW_LEN; k++) begin
            ring_next[k] = ring_reg[k-1];
        end
        fill_next = (fill_reg == CNT_W'(WINDOW_LEN)) ? fill_reg : fill_reg + 1'b1;
    end

    // Sequencer: load the scanner (the scanner starts the divide when the sum is ready),
    // wait for both units, then hand the result to the output register.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (scan_stat.rank_done && div_stat.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            clamp_low_reg  <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            clamp_high_reg <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            ring_reg       <= '0;
            fill_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CLAMP_LOW:  clamp_low_reg  <= $signed(cfg_wr_data);
                    REG_CLAMP_HIGH: clamp_high_reg <= $signed(cfg_wr_data);
                    default: ;
                endcase
            end
            if (accept) begin
                ring_reg <= ring_next;
                fill_reg <= fill_next;
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            clamped_reg <= clamp_val;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_clamped_reg <= clamped_reg;
            m_median_reg  <= median;
            m_mean_reg    <= quotient;
            m_fill_reg    <= fill_reg;
        end
    end

    assign scan_ctl.load  = state_reg == ST_LOAD;
    assign scan_ctl.count = fill_reg;

    cmwm_scan #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (scan_ctl),
        .window  (ring_reg),
        .stat    (scan_stat),
        .acc     (acc),
        .median  (median)
    );

    cmwm_divider #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_stat.mac_done),
        .dividend (acc),
        .divisor  (total_weight(fill_reg)),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_fill_reg, m_mean_reg, m_median_reg, m_clamped_reg});

    // An accepted request moves straight into the load step and drops ready.
    `CMWM_ASSERT_NEXT(a_accept_loads, aclk, aresetn, accept, (state_reg == ST_LOAD) && !s_tready)
    // Both shared units are finished before a result is handed over.
    `CMWM_ASSERT_SAME(a_done_units_idle, aclk, aresetn, state_reg == ST_DONE, scan_stat.rank_done && div_stat.done && !div_stat.busy)
    // A delivered result always reports between one and a full window of samples.
    `CMWM_ASSERT_SAME(a_fill_range, aclk, aresetn, m_tvalid_reg, (m_fill_reg != '0) && (m_fill_reg <= CNT_W'(WINDOW_LEN)))

endmodule

/* hdl/cmwm_scan.sv */
// Window scanner: one compare and one multiply-accumulate reused over rotating copies.
module cmwm_scan
    import cmwm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int ACC_W = SAMPLE_BITS + 7
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  scan_ctl_t                              ctl,
    input  logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] window,
    output scan_stat_t                             stat,
    output logic signed [ACC_W-1:0]                acc,
    output logic signed [SAMPLE_BITS-1:0]          median
);

    logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] inner_reg;
    logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] outer_reg;
    logic [CNT_W-1:0]              i_reg, j_reg, lt_reg, count_reg;
    logic                          busy_reg, rank_done_reg, mac_done_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [SAMPLE_BITS-1:0] median_reg;

    logic signed [SAMPLE_BITS-1:0] v, cand;
    logic                          j_valid, i_valid, less, last_j, last_i;
    logic [CNT_W-1:0]              lt_sum;
    logic signed [SAMPLE_BITS+7:0] product;

    always_comb begin
        v       = $signed(inner_reg[0]);
        cand    = $signed(outer_reg[0]);
        j_valid = j_reg < count_reg;
        i_valid = i_reg < count_reg;
        // Rank with ties broken by window position.
        less    = j_valid && ((v < cand) || ((v == cand) && (j_reg < i_reg)));
        lt_sum  = lt_reg + {{(CNT_W-1){1'b0}}, less};
        last_j  = j_reg == CNT_W'(WINDOW_LEN - 1);
        last_i  = i_reg == CNT_W'(WINDOW_LEN - 1);
        product = v * $signed({1'b0, weight_of(j_reg)});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            rank_done_reg <= 1'b0;
            mac_done_reg  <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            lt_reg        <= '0;
        end else begin
            mac_done_reg <= 1'b0;
            if (ctl.load) begin
                busy_reg      <= 1'b1;
                rank_done_reg <= 1'b0;
                i_reg         <= '0;
                j_reg         <= '0;
                lt_reg        <= '0;
            end else if (busy_reg) begin
                j_reg  <= last_j ? '0 : j_reg + 1'b1;
                lt_reg <= last_j ? '0 : lt_sum;
                if (last_j) begin
                    i_reg <= last_i ? '0 : i_reg + 1'b1;
                    if (i_reg == '0) begin
                        mac_done_reg <= 1'b1;
                    end
                    if (last_i) begin
                        busy_reg      <= 1'b0;
                        rank_done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            inner_reg <= window;
            outer_reg <= window;
            acc_reg   <= '0;
            count_reg <= ctl.count;
        end else if (busy_reg) begin
            for (int k = 0; k < WINDOW_LEN; k++) begin
                inner_reg[k] <= inner_reg[(k + 1) % WINDOW_LEN];
            end
            // First pass over the window also accumulates the weighted sum.
            if ((i_reg == '0) && j_valid) begin
                acc_reg <= acc_reg + product[ACC_W-1:0];
            end
            if (last_j) begin
                for (int k = 0; k < WINDOW_LEN; k++) begin
                    outer_reg[k] <= outer_reg[(k + 1) % WINDOW_LEN];
                end
                if (i_valid && (lt_sum == (count_reg >> 1))) begin
                    median_reg <= cand;
                end
            end
        end
    end

    assign stat.mac_done  = mac_done_reg;
    assign stat.rank_done = rank_done_reg;
    assign acc            = acc_reg;
    assign median         = median_reg;

endmodule

/* hdl/cmwm_divider.sv */
// Bit-serial restoring divider for the Q8 weighted mean, truncating toward zero.
module cmwm_divider
    import cmwm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int ACC_W  = SAMPLE_BITS + 7,
    localparam int NUM_W  = SAMPLE_BITS + 14,
    localparam int QUOT_W = SAMPLE_BITS + 8,
    localparam int STEP_W = $clog2(NUM_W)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [ACC_W-1:0]  dividend,
    input  logic [WEIGHT_W-1:0]      divisor,
    output div_stat_t                stat,
    output logic signed [QUOT_W-1:0] quotient
);

    logic [NUM_W-1:0]    q_reg;
    logic [WEIGHT_W-1:0] rem_reg, div_reg;
    logic                neg_reg, busy_reg, done_reg;
    logic [STEP_W-1:0]   step_reg;

    logic [ACC_W-1:0]    mag;
    logic [WEIGHT_W:0]   trial, diff;
    logic                ge;
    logic [QUOT_W-1:0]   q_mag;

    always_comb begin
        mag   = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
        trial = {rem_reg, q_reg[NUM_W-1]};
        ge    = trial >= {1'b0, div_reg};
        diff  = trial - {1'b0, div_reg};
        q_mag = q_reg[QUOT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // Scale by 256 while loading the magnitude.
            q_reg   <= {mag[ACC_W-2:0], 8'd0};
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= dividend[ACC_W-1];
        end else if (busy_reg) begin
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[WEIGHT_W-1:0] : trial[WEIGHT_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = neg_reg ? -$signed(q_mag) : $signed(q_mag);

endmodule

/* sim/tb_clamp_median_weighted_mean_core.sv */
// Self-checking testbench for the clamp, running median and weighted mean core.
`timescale 1ns / 1ps

module tb_clamp_median_weighted_mean_core;
    import cmwm_pkg::*;

    localparam int SB          = 16;
    localparam int S_W         = ((SB + 7) / 8) * 8;
    localparam int M_W         = ((3 * SB + 8 + CNT_W + 7) / 8) * 8;
    localparam int MEAN_BITS   = SB + 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int STALL_LEN   = 300;
    localparam int SETTLE_LEN  = 60;   // longer than one request's full pass

    // Weights by age, newest first.
    localparam int AGE_WEIGHT [WINDOW_LEN] = '{40, 30, 15, 10, 5};

    typedef struct {
        logic [SB-1:0]        clamped;
        logic [SB-1:0]        median;
        logic [MEAN_BITS-1:0] mean_q8;
        logic [CNT_W-1:0]     fill;
    } window_result_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_CLAMP_LOW;
    logic [SB-1:0]        cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_W-1:0]       s_tdata     = '0;   // raw_sample
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_W-1:0]       m_tdata;            // clamped_sample, median_value,
                                              // weighted_mean_q8, fill_count

    // Predictor copy of the limits and the sample window.
    logic signed [SB-1:0] lim_low  = -16'sd32768;
    logic signed [SB-1:0] lim_high = 16'sd32767;
    logic signed [SB-1:0] window_ring [WINDOW_LEN] = '{default: '0};
    int                   next_slot  = 0;
    bit                   window_full = 1'b0;

    logic [SB-1:0]  raw_samples_q [$];      // samples waiting to be offered
    window_result_t window_results_q [$];   // predicted results, oldest first
    window_result_t want;

    int  send_idle_pct = 16;
    int  recv_idle_pct = 66;
    logic stall_kick   = 1'b0;
    int  stall_left    = 0;
    int  error_count   = 0;
    int  cycle_count   = 0;

    clamp_median_weighted_mean_core #(
        .SAMPLE_BITS(SB)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Clamp one sample, push it into the window and work out the result it causes.
    function automatic window_result_t apply_sample(input logic [SB-1:0] raw);
        logic signed [SB-1:0] x;
        longint               ranked [WINDOW_LEN];
        longint               acc;
        longint               wsum;
        longint               t;
        int                   cnt;
        int                   i;
        int                   j;
        int                   age_slot;
        window_result_t       r;
        x = raw;
        // low limit wins over high limit when the two are crossed
        if (x < lim_low) begin
            x = lim_low;
        end else if (x > lim_high) begin
            x = lim_high;
        end
        window_ring[next_slot] = x;
        next_slot = (next_slot + 1) % WINDOW_LEN;
        if (next_slot == 0) begin
            window_full = 1'b1;
        end
        cnt = window_full ? WINDOW_LEN : next_slot;
        // insertion sort over the filled slots only
        for (i = 0; i < cnt; i++) begin
            ranked[i] = longint'(window_ring[i]);
        end
        for (i = 1; i < cnt; i++) begin
            t = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] > t) begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = t;
        end
        acc  = 0;
        wsum = 0;
        for (i = 0; i < cnt; i++) begin
            age_slot = (next_slot + WINDOW_LEN - 1 - i) % WINDOW_LEN;
            acc  += longint'(window_ring[age_slot]) * AGE_WEIGHT[i];
            wsum += AGE_WEIGHT[i];
        end
        r.clamped = x;
        r.median  = ranked[cnt / 2][SB-1:0];
        r.mean_q8 = MEAN_BITS'((acc * 256) / wsum);   // truncates toward zero
        r.fill    = CNT_W'(cnt);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint wanted);
        error_count++;
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, wanted, $realtime);
    endtask

    // Sender: record each accepted request, then offer the next sample or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                window_results_q.push_back(apply_sample(s_tdata[SB-1:0]));
            end
            if (!s_tvalid || s_tready) begin
                if (raw_samples_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_W'(raw_samples_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down here so the sender keeps running.
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left <= 0;
        end else if (stall_kick) begin
            stall_left <= STALL_LEN;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // Receiver: drop ready while stalled, otherwise idle at the current rate.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (window_results_q.size() == 0) begin
                report_mismatch("unexpected result, clamped", longint'($signed(m_tdata[15:0])), 0);
            end else begin
                want = window_results_q.pop_front();
                if (m_tdata[15:0] !== want.clamped) begin
                    report_mismatch("clamped_sample", longint'($signed(m_tdata[15:0])),
                                    longint'($signed(want.clamped)));
                end
                if (m_tdata[31:16] !== want.median) begin
                    report_mismatch("median_value", longint'($signed(m_tdata[31:16])),
                                    longint'($signed(want.median)));
                end
                if (m_tdata[55:32] !== want.mean_q8) begin
                    report_mismatch("weighted_mean_q8", longint'($signed(m_tdata[55:32])),
                                    longint'($signed(want.mean_q8)));
                end
                if (m_tdata[58:56] !== want.fill) begin
                    report_mismatch("fill_count", longint'(m_tdata[58:56]),
                                    longint'(want.fill));
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Write one limit register; only called while the block is idle.
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [SB-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        if (idx == REG_CLAMP_LOW) begin
            lim_low = value;
        end else begin
            lim_high = value;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_limits(input logic [SB-1:0] lo, input logic [SB-1:0] hi);
        write_limit(REG_CLAMP_LOW, lo);
        write_limit(REG_CLAMP_HIGH, hi);
    endtask

    // Hold until every sample is accepted and every predicted result has arrived.
    task automatic drain_window();
        do begin
            @(negedge aclk);
        end while (raw_samples_q.size() != 0 || s_tvalid || window_results_q.size() != 0);
    endtask

    task automatic kick_long_stall();
        @(posedge aclk);
        stall_kick <= 1'b1;
        @(posedge aclk);
        stall_kick <= 1'b0;
    endtask

    // Mostly full-range samples, with a share aimed at the limits and the extremes.
    function automatic logic [SB-1:0] pick_sample();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6) begin
            return SB'($urandom);
        end else if (sel < 8) begin
            return SB'(int'(lim_low) + $urandom_range(4) - 2);
        end else if (sel == 8) begin
            return SB'(int'(lim_high) + $urandom_range(4) - 2);
        end else begin
            return $urandom_range(1) ? 16'h8000 : 16'h7fff;
        end
    endfunction

    // One random run: half the samples, a full pause, then the rest.
    task automatic run_random(input int n, input bit with_stall);
        int k;
        for (k = 0; k < n / 2; k++) begin
            raw_samples_q.push_back(pick_sample());
        end
        if (with_stall) begin
            kick_long_stall();
        end
        drain_window();
        for (k = n / 2; k < n; k++) begin
            raw_samples_q.push_back(pick_sample());
        end
        drain_window();
    endtask

    // Random limits; crossed asks for low above high.
    task automatic random_limits(input bit crossed);
        logic signed [SB-1:0] a;
        logic signed [SB-1:0] b;
        a = SB'($urandom);
        b = SB'($urandom);
        if ((a > b) != crossed) begin
            set_limits(b, a);
        end else begin
            set_limits(a, b);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset limits, window filling then wrapping, extreme samples.
        raw_samples_q = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001,
                          16'h5555, 16'haaaa};
        kick_long_stall();
        drain_window();

        // Ordinary limits: on and just past each one, plus the extremes.
        set_limits(-16'sd100, 16'sd100);
        raw_samples_q = '{-16'sd101, -16'sd100, 16'sd100, 16'sd101, 16'h8000, 16'h7fff};
        drain_window();

        // Crossed limits: below low gives low, anything else above high gives high.
        set_limits(16'sd50, -16'sd50);
        raw_samples_q = '{16'sd60, -16'sd60, 16'sd0, 16'sd50};
        drain_window();

        // Crossed at the very extremes.
        set_limits(16'h7fff, 16'h8000);
        raw_samples_q = '{16'h7fff, 16'h8000, 16'sd5};
        drain_window();

        // Both limits at the minimum.
        set_limits(16'h8000, 16'h8000);
        raw_samples_q = '{16'h7fff, 16'h8000};
        drain_window();

        // Random: sender idles lightly, receiver heavily.
        send_idle_pct = 16;
        recv_idle_pct = 66;
        set_limits(16'h8000, 16'h7fff);
        run_random(260, 1'b1);
        random_limits(1'b0);
        run_random(260, 1'b0);

        // Random: the other way round.
        send_idle_pct = 66;
        recv_idle_pct = 16;
        set_limits(-16'sd8, 16'sd8);
        run_random(260, 1'b1);
        random_limits(1'b1);
        run_random(260, 1'b0);

        // Random: no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limits(16'h7fff, 16'h7fff);
        run_random(250, 1'b1);
        random_limits(1'b0);
        run_random(250, 1'b0);

        drain_window();
        repeat (SETTLE_LEN) @(posedge aclk);
        while (window_results_q.size() != 0) begin
            want = window_results_q.pop_front();
            report_mismatch("missing result, clamped", 0, longint'($signed(want.clamped)));
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/cmwm_pkg.sv
hdl/cmwm_scan.sv
hdl/cmwm_divider.sv
hdl/clamp_median_weighted_mean_core.sv
sim/tb_clamp_median_weighted_mean_core.sv
